// File: rtl/u16u8_pkg.sv
`default_nettype none
package u16u8_pkg;

	localparam int unsigned QueueDepth = 2;

	localparam logic [20:0] ReplCp  = 21'h00FFFD;
	localparam logic [20:0] MaxCp   = 21'h10FFFF;
	localparam logic [20:0] SuppBase = 21'h010000;

	// Byte segment codes of the serializer.
	localparam logic SegRepl = 1'b0;
	localparam logic SegCp   = 1'b1;

	// Encoded length minus one.
	localparam logic [1:0] Len1 = 2'd0;
	localparam logic [1:0] Len2 = 2'd1;
	localparam logic [1:0] Len3 = 2'd2;
	localparam logic [1:0] Len4 = 2'd3;

	// One classified item: an optional U+FFFD for a dropped high surrogate,
	// then an optional code point with its encoded length.
	typedef struct packed {
		logic        repl;
		logic        cp_ok;
		logic [20:0] cp;
		logic [1:0]  lm1;
		logic        last;
	} job_t;

	function automatic logic [1:0] utf8_lm1(input logic [20:0] cp);
		logic [1:0] r;
		if (cp <= 21'h7F) begin
			r = Len1;
		end else if (cp <= 21'h7FF) begin
			r = Len2;
		end else if (cp <= 21'hFFFF) begin
			r = Len3;
		end else begin
			r = Len4;
		end
		return r;
	endfunction

	function automatic logic [7:0] utf8_byte_at(input logic [20:0] cp, input logic [1:0] lm1,
			input logic [1:0] idx);
		logic [7:0] b;
		b = {2'b10, cp[5:0]};
		unique case (lm1)
			Len1: b = cp[7:0];
			Len2: begin
				if (idx == 2'd0) b = {3'b110, cp[10:6]};
			end
			Len3: begin
				if (idx == 2'd0) b = {4'b1110, cp[15:12]};
				else if (idx == 2'd1) b = {2'b10, cp[11:6]};
			end
			Len4: begin
				if (idx == 2'd0) b = {5'b11110, cp[20:18]};
				else if (idx == 2'd1) b = {2'b10, cp[17:12]};
				else if (idx == 2'd2) b = {2'b10, cp[11:6]};
			end
			default: b = {2'b10, cp[5:0]};
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

// File: rtl/u16u8_if.sv
`default_nettype none
interface u16u8_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] code_unit;
	logic        last_unit;

	modport source (output valid, output code_unit, output last_unit, input ready);
	modport sink (input valid, input code_unit, input last_unit, output ready);
endinterface

interface u16u8_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] utf8_byte;
	logic       last_of_run;
	logic       end_of_string;

	modport source (output valid, output utf8_byte, output last_of_run, output end_of_string,
		input ready);
	modport sink (input valid, input utf8_byte, input last_of_run, input end_of_string,
		output ready);
endinterface
`default_nettype wire

// File: rtl/u16u8_front.sv
`default_nettype none
module u16u8_front
	import u16u8_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cfg_we,
	input  wire logic  cfg_wdata,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire logic [31:0] code_unit,
	input  wire logic  last_unit,
	input  wire logic  q_full,
	output logic       q_push,
	output job_t       q_job
);

	logic        mode32_q;
	logic        pending_q;
	logic [9:0]  held_q;
	logic        accept;
	logic [15:0] u;
	logic        is_high;
	logic        is_low;
	logic        hold_new;
	job_t        job;

	assign u       = code_unit[15:0];
	assign is_high = (u >= 16'hD800) && (u <= 16'hDBFF);
	assign is_low  = (u >= 16'hDC00) && (u <= 16'hDFFF);

	always_comb begin
		job      = '0;
		job.last = last_unit;
		hold_new = 1'b0;
		if (mode32_q) begin
			job.cp_ok = 1'b1;
			job.cp    = (code_unit > 32'(MaxCp)) ? ReplCp : code_unit[20:0];
		end else if (pending_q && is_low) begin
			job.cp_ok = 1'b1;
			job.cp    = SuppBase + {1'b0, held_q, u[9:0]};
		end else begin
			job.repl = pending_q;
			if (is_high) begin
				if (last_unit) begin
					job.cp_ok = 1'b1;
					job.cp    = ReplCp;
				end else begin
					hold_new = 1'b1;
				end
			end else if (is_low) begin
				job.cp_ok = 1'b1;
				job.cp    = ReplCp;
			end else begin
				job.cp_ok = 1'b1;
				job.cp    = {5'd0, u};
			end
		end
		job.lm1 = utf8_lm1(job.cp);
	end

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign q_push   = accept && (job.repl || job.cp_ok);
	assign q_job    = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode32_q  <= 1'b0;
			pending_q <= 1'b0;
		end else if (cfg_we) begin
			mode32_q  <= cfg_wdata;
			pending_q <= 1'b0;
		end else if (accept) begin
			pending_q <= hold_new;
		end
	end

	// Only the low ten bits of a high surrogate carry information.
	always_ff @(posedge clk) begin
		if (accept && hold_new) begin
			held_q <= u[9:0];
		end
	end

	// A newly held surrogate may still push the replacement for the one it displaces.
	a_hold_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && hold_new) |-> (!job.cp_ok && (q_push == pending_q)))
		else $error("held surrogate produced a queue entry");
	a_mode32_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		mode32_q |-> !pending_q)
		else $error("surrogate pending in 32-bit mode");

endmodule
`default_nettype wire

// File: rtl/u16u8_queue.sv
`default_nettype none
module u16u8_queue
	import u16u8_pkg::*;
#(
	parameter int unsigned DEPTH = QueueDepth
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  job_t      wr_job,
	output logic      full,
	input  wire logic pop,
	output logic      rd_valid,
	output job_t      rd_job
);

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

	job_t            mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full     = (cnt_q == FullCnt);
	assign rd_valid = (cnt_q != '0);
	assign rd_job   = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into a full queue");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FullCnt)
		else $error("queue count out of range");
	a_entry_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid |-> (rd_job.repl || rd_job.cp_ok))
		else $error("queue entry carries no bytes");

endmodule
`default_nettype wire

// File: rtl/u16u8_back.sv
`default_nettype none
module u16u8_back
	import u16u8_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  q_valid,
	input  job_t       q_job,
	output logic       q_pop,
	output logic       out_valid,
	input  wire logic  out_ready,
	output logic [7:0] utf8_byte,
	output logic       last_of_run,
	output logic       end_of_string
);

	job_t        job_q;
	logic        busy_q;
	logic        seg_q;
	logic [1:0]  idx_q;
	logic        ov_q;
	logic [7:0]  byte_q;
	logic        lor_q;
	logic        eos_q;
	logic        adv;
	logic [20:0] cur_cp;
	logic [1:0]  cur_lm1;
	logic        seg_end;
	logic        job_end;

	assign adv     = busy_q && (!ov_q || out_ready);
	assign cur_cp  = (seg_q == SegCp) ? job_q.cp : ReplCp;
	assign cur_lm1 = (seg_q == SegCp) ? job_q.lm1 : Len3;
	assign seg_end = (idx_q == cur_lm1);
	assign job_end = seg_end && ((seg_q == SegCp) || !job_q.cp_ok);
	// The next entry is taken in the same cycle that the last byte of this one is loaded into the output register.
	assign q_pop   = q_valid && (!busy_q || (adv && job_end));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			seg_q  <= SegRepl;
			idx_q  <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				seg_q  <= q_job.repl ? SegRepl : SegCp;
				idx_q  <= '0;
			end else if (adv && job_end) begin
				busy_q <= 1'b0;
			end else if (adv) begin
				if (seg_end) begin
					seg_q <= SegCp;
					idx_q <= '0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (adv) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_job;
		end
		if (adv) begin
			byte_q <= utf8_byte_at(cur_cp, cur_lm1, idx_q);
			lor_q  <= job_end;
			eos_q  <= job_end && job_q.last;
		end
	end

	assign out_valid     = ov_q;
	assign utf8_byte     = byte_q;
	assign last_of_run   = lor_q;
	assign end_of_string = eos_q;

	a_eos_on_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && eos_q) |-> lor_q)
		else $error("end of string away from the end of a run");
	a_repl_seg: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && seg_q == SegRepl) |-> job_q.repl)
		else $error("replacement segment on an entry without one");
	a_cp_seg: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && seg_q == SegCp) |-> job_q.cp_ok)
		else $error("code point segment on an entry without one");

endmodule
`default_nettype wire

// File: rtl/utf16_to_utf8_encoder_top.sv
// Channel   Dir  Payload                                      Transfer
// in_ch     in   code_unit[31:0], last_unit                   valid && ready
// out_ch    out  utf8_byte[7:0], last_of_run, end_of_string   valid && ready
// cfg       in   cfg_wdata (wide_unit_32bit)                  cfg_we
//
// The output emits one byte per cycle while out_ch.ready holds; an item causes 0 to 6
// bytes (1 to 3 for a BMP character), sent in order by the back-end byte serializer.
// An input transfer is taken whenever the classify queue has room, even while the output
// register is stalled; its bytes pass through a queue entry, then the output register.
// Reset clears the mode bit, the pending surrogate, the queue and the output register.
`default_nettype none
module utf16_to_utf8_encoder_top
	import u16u8_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   cfg_we,
	input  wire logic   cfg_wdata,
	u16u8_in_if.sink    in_ch,
	u16u8_out_if.source out_ch
);

	logic q_full;
	logic q_push;
	job_t q_wr_job;
	logic q_pop;
	logic q_valid;
	job_t q_rd_job;

	u16u8_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.code_unit (in_ch.code_unit),
		.last_unit (in_ch.last_unit),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_job     (q_wr_job)
	);

	u16u8_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_job   (q_wr_job),
		.full     (q_full),
		.pop      (q_pop),
		.rd_valid (q_valid),
		.rd_job   (q_rd_job)
	);

	u16u8_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_job         (q_rd_job),
		.q_pop         (q_pop),
		.out_valid     (out_ch.valid),
		.out_ready     (out_ch.ready),
		.utf8_byte     (out_ch.utf8_byte),
		.last_of_run   (out_ch.last_of_run),
		.end_of_string (out_ch.end_of_string)
	);

endmodule
`default_nettype wire
